// ===== design/stat_pkg.sv =====
// Shared types and constants for the section table address translation block.
// No dependencies; used by section_table_address_translation.
package stat_pkg;

  localparam int unsigned MAX_SECTIONS = 18;
  localparam int unsigned IDX_W        = $clog2(MAX_SECTIONS);
  localparam int unsigned CNT_W        = $clog2(MAX_SECTIONS + 1);

  localparam logic [31:0] RAM_FLOOR = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_CLEAR     = 2'd0,
    CMD_LOAD      = 2'd1,
    CMD_TRANSLATE = 2'd2,
    CMD_NONE      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_TRANSLATED = 3'd0,
    STS_PURE       = 3'd1,
    STS_BEFORE     = 3'd2,
    STS_PAST       = 3'd3,
    STS_LOADED     = 3'd4,
    STS_SKIPPED    = 3'd5,
    STS_FULL       = 3'd6,
    STS_CLEARED    = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TR_RD,
    S_TR_CMP,
    S_LD_RD,
    S_LD_CMP,
    S_LD_PUT
  } state_t;

  typedef struct packed {
    logic [31:0] ram;
    logic [31:0] len;
    logic [31:0] off;
  } sect_entry_t;

  localparam int unsigned ENTRY_W = $bits(sect_entry_t);

endpackage

// ===== design/stat_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module stat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/section_table_address_translation.sv =====
// Section table address translation: sorted section table in one RAM plus its walker.
// Depends on stat_pkg and stat_ram.
//
// A transaction is taken when start is high and busy is low; busy stays high
// until its result has been issued. Each result appears for exactly one cycle
// with out_valid and cannot be stalled. Clear, skipped or full loads, the
// unused command, translations below 0x80000000 and translations on an empty
// table finish straight from idle. A translation walks the table one entry per cycle
// through the RAM read port: a read state, then a compare state that reads the next
// entry on a miss and ends on a hit or at the last entry. A load shifts the greater
// entries up one per cycle from the end of the table and writes the new entry in the
// gap, or writes it directly on an empty table. The table is not cleared by reset;
// the entry count is.
module section_table_address_translation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_address,
  input  logic [31:0] in_entry_file_offset,
  input  logic [31:0] in_entry_ram_base,
  input  logic [31:0] in_entry_length,
  output logic        out_valid,
  output logic [31:0] out_file_offset,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  stat_pkg::state_t state_r, state_nxt;

  logic [31:0]                   start_r;
  logic [stat_pkg::CNT_W-1:0]    cnt_r;
  logic [31:0]                   code_lo_r, code_hi_r, last_ram_r;
  logic [stat_pkg::IDX_W-1:0]    idx_r;
  logic [31:0]                   addr_r;
  stat_pkg::status_t             sts_r;
  stat_pkg::sect_entry_t         new_r;
  logic                          out_valid_r;
  logic [31:0]                   out_off_r;
  stat_pkg::status_t             out_sts_r;

  logic                          accept;
  stat_pkg::cmd_t                cmd;
  stat_pkg::sect_entry_t         rd_entry;
  logic [stat_pkg::ENTRY_W-1:0]  rd_data;
  logic [31:0]                   end_sum, xlat;
  logic                          hit, last, greater;
  logic                          mem_we, mem_re;
  logic [stat_pkg::IDX_W-1:0]    mem_waddr, mem_raddr;
  stat_pkg::sect_entry_t         mem_wdata;
  logic                          done;
  logic [31:0]                   done_off;
  stat_pkg::status_t             done_sts, in_sts;
  logic                          ld_ok;

  assign accept   = start && (state_r == stat_pkg::S_IDLE);
  assign busy     = (state_r != stat_pkg::S_IDLE);
  assign cmd      = stat_pkg::cmd_t'(in_cmd);
  assign rd_entry = stat_pkg::sect_entry_t'(rd_data);
  assign end_sum  = rd_entry.ram + rd_entry.len;
  assign xlat     = start_r + rd_entry.off + addr_r - rd_entry.ram;
  assign hit      = addr_r <= end_sum;
  assign last     = (stat_pkg::CNT_W'(idx_r) + 1'b1) == cnt_r;
  assign greater  = rd_entry.ram > new_r.ram;
  assign ld_ok    = (in_entry_length != 32'd0) && (cnt_r < stat_pkg::CNT_W'(stat_pkg::MAX_SECTIONS));

  always_comb begin
    if (in_address > code_hi_r) begin
      in_sts = stat_pkg::STS_PAST;
    end else if (in_address < stat_pkg::RAM_FLOOR) begin
      in_sts = stat_pkg::STS_PURE;
    end else if (in_address < code_lo_r) begin
      in_sts = stat_pkg::STS_BEFORE;
    end else begin
      in_sts = stat_pkg::STS_TRANSLATED;
    end
  end

  stat_ram #(
    .WIDTH (stat_pkg::ENTRY_W),
    .DEPTH (stat_pkg::MAX_SECTIONS)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stat_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            stat_pkg::CMD_LOAD: begin
              if (ld_ok) begin
                state_nxt = (cnt_r == '0) ? stat_pkg::S_LD_PUT : stat_pkg::S_LD_RD;
              end
            end
            stat_pkg::CMD_TRANSLATE: begin
              if ((in_address >= stat_pkg::RAM_FLOOR) && (cnt_r != '0)) begin
                state_nxt = stat_pkg::S_TR_RD;
              end
            end
            stat_pkg::CMD_CLEAR, stat_pkg::CMD_NONE: state_nxt = stat_pkg::S_IDLE;
          endcase
        end
      end
      stat_pkg::S_TR_RD:  state_nxt = stat_pkg::S_TR_CMP;
      stat_pkg::S_TR_CMP: begin
        if (hit || last) begin
          state_nxt = stat_pkg::S_IDLE;
        end
      end
      stat_pkg::S_LD_RD:  state_nxt = stat_pkg::S_LD_CMP;
      stat_pkg::S_LD_CMP: begin
        if (!greater) begin
          state_nxt = stat_pkg::S_IDLE;
        end else if (idx_r == '0) begin
          state_nxt = stat_pkg::S_LD_PUT;
        end
      end
      stat_pkg::S_LD_PUT: state_nxt = stat_pkg::S_IDLE;
      default:            state_nxt = stat_pkg::S_IDLE;
    endcase
  end

  // memory control and results
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = idx_r + 1'b1;
    mem_raddr = idx_r;
    mem_wdata = new_r;
    done      = 1'b0;
    done_off  = 32'd0;
    done_sts  = sts_r;
    unique case (state_r)
      stat_pkg::S_IDLE: begin
        if (accept) begin
          unique case (cmd)
            stat_pkg::CMD_CLEAR: begin
              done     = 1'b1;
              done_sts = stat_pkg::STS_CLEARED;
            end
            stat_pkg::CMD_LOAD: begin
              done     = !ld_ok;
              done_sts = (in_entry_length == 32'd0) ? stat_pkg::STS_SKIPPED
                                                    : stat_pkg::STS_FULL;
            end
            stat_pkg::CMD_TRANSLATE: begin
              done     = (in_address < stat_pkg::RAM_FLOOR) || (cnt_r == '0);
              done_off = (in_address < stat_pkg::RAM_FLOOR) ? in_address : 32'd0;
              done_sts = in_sts;
            end
            stat_pkg::CMD_NONE: done = 1'b0;
          endcase
        end
      end
      stat_pkg::S_TR_RD: mem_re = 1'b1;
      stat_pkg::S_TR_CMP: begin
        if (hit) begin
          done     = 1'b1;
          done_off = xlat;
        end else if (last) begin
          done = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_r + 1'b1;
        end
      end
      stat_pkg::S_LD_RD: mem_re = 1'b1;
      stat_pkg::S_LD_CMP: begin
        mem_we = 1'b1;
        if (greater) begin
          mem_wdata = rd_entry;
          if (idx_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = idx_r - 1'b1;
          end
        end else begin
          done     = 1'b1;
          done_sts = stat_pkg::STS_LOADED;
        end
      end
      stat_pkg::S_LD_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        done      = 1'b1;
        done_sts  = stat_pkg::STS_LOADED;
      end
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stat_pkg::S_IDLE;
      start_r     <= 32'd0;
      cnt_r       <= '0;
      code_lo_r   <= 32'd0;
      code_hi_r   <= 32'd0;
      last_ram_r  <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= done;
      if (cfg_we) begin
        start_r <= cfg_wdata;
      end
      if (accept && (cmd == stat_pkg::CMD_CLEAR)) begin
        cnt_r     <= '0;
        code_lo_r <= 32'd0;
        code_hi_r <= 32'd0;
      end
      if (accept && (cmd == stat_pkg::CMD_LOAD) && ld_ok) begin
        cnt_r <= cnt_r + 1'b1;
        if ((cnt_r == '0) || (in_entry_ram_base < code_lo_r)) begin
          code_lo_r <= in_entry_ram_base;
        end
        if ((cnt_r == '0) || (in_entry_ram_base >= last_ram_r)) begin
          code_hi_r  <= in_entry_ram_base + in_entry_length;
          last_ram_r <= in_entry_ram_base;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r    <= in_address;
      sts_r     <= in_sts;
      new_r.ram <= in_entry_ram_base;
      new_r.len <= in_entry_length;
      new_r.off <= in_entry_file_offset;
      idx_r     <= (cmd == stat_pkg::CMD_LOAD) ? stat_pkg::IDX_W'(cnt_r - 1'b1) : '0;
    end else if ((state_r == stat_pkg::S_TR_CMP) && !hit && !last) begin
      idx_r <= idx_r + 1'b1;
    end else if ((state_r == stat_pkg::S_LD_CMP) && greater && (idx_r != '0)) begin
      idx_r <= idx_r - 1'b1;
    end
    if (done) begin
      out_off_r <= done_off;
      out_sts_r <= done_sts;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_file_offset = out_off_r;
  assign out_status      = out_sts_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= stat_pkg::CNT_W'(stat_pkg::MAX_SECTIONS))
    else $error("section count above table depth");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("table read and write hit the same entry");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transaction");

  a_unused_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (cmd == stat_pkg::CMD_NONE)) |=> !out_valid)
    else $error("unused command produced a result");

endmodule

// ===== bench/section_table_address_translation_tb.sv =====
// Testbench for section_table_address_translation: directed and random clear, load and translate
// transactions, checked against an in-bench section map model. Depends on stat_pkg and the RTL.
`timescale 1ns / 100ps

module section_table_address_translation_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned TARGET_ITEMS = 950;

  typedef struct packed {
    logic [31:0]       offset;
    stat_pkg::status_t status;
  } xlat_result_t;

  class section_map_scoreboard;
    logic [31:0]  prog_start;
    logic [31:0]  sec_base [stat_pkg::MAX_SECTIONS];
    logic [31:0]  sec_size [stat_pkg::MAX_SECTIONS];
    logic [31:0]  sec_foff [stat_pkg::MAX_SECTIONS];
    int unsigned  n_sec;
    logic [31:0]  span_lo;
    logic [31:0]  span_hi;
    xlat_result_t awaited_results[$];
    int unsigned  mismatches;
    int unsigned  status_seen [8];

    function new();
      prog_start = '0;
      n_sec = 0;
      span_lo = '0;
      span_hi = '0;
      mismatches = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void update_span();
      if (n_sec == 0) begin
        span_lo = '0;
        span_hi = '0;
      end else begin
        span_lo = sec_base[0];
        span_hi = sec_base[n_sec-1] + sec_size[n_sec-1];
      end
    endfunction

    function stat_pkg::status_t place_section(logic [31:0] off, logic [31:0] base,
                                              logic [31:0] size);
      int unsigned pos;
      int unsigned k;
      if (size == 0) return stat_pkg::STS_SKIPPED;
      if (n_sec >= stat_pkg::MAX_SECTIONS) return stat_pkg::STS_FULL;
      pos = 0;
      while (pos < n_sec && sec_base[pos] <= base) pos++;
      for (k = n_sec; k > pos; k--) begin
        sec_base[k] = sec_base[k-1];
        sec_size[k] = sec_size[k-1];
        sec_foff[k] = sec_foff[k-1];
      end
      sec_base[pos] = base;
      sec_size[pos] = size;
      sec_foff[pos] = off;
      n_sec++;
      update_span();
      return stat_pkg::STS_LOADED;
    endfunction

    function stat_pkg::status_t classify(logic [31:0] a);
      if (a > span_hi) return stat_pkg::STS_PAST;
      if (a < stat_pkg::RAM_FLOOR) return stat_pkg::STS_PURE;
      if (a < span_lo) return stat_pkg::STS_BEFORE;
      return stat_pkg::STS_TRANSLATED;
    endfunction

    function logic [31:0] map_address(logic [31:0] a);
      logic [31:0] last_byte;
      if (a < stat_pkg::RAM_FLOOR) return a;
      for (int unsigned i = 0; i < n_sec; i++) begin
        last_byte = sec_base[i] + sec_size[i];
        if (a <= last_byte) return prog_start + sec_foff[i] + (a - sec_base[i]);
      end
      return '0;
    endfunction

    function void apply_command(stat_pkg::cmd_t cmd, logic [31:0] a, logic [31:0] off,
                                logic [31:0] base, logic [31:0] size);
      xlat_result_t r;
      r.offset = '0;
      r.status = stat_pkg::STS_CLEARED;
      case (cmd)
        stat_pkg::CMD_CLEAR: begin
          n_sec = 0;
          update_span();
        end
        stat_pkg::CMD_LOAD: r.status = place_section(off, base, size);
        stat_pkg::CMD_TRANSLATE: begin
          r.status = classify(a);
          r.offset = map_address(a);
        end
        default: return;
      endcase
      awaited_results.insert(awaited_results.size(), r);
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 50) $display("ERROR @%0t: %s", $time, msg);
    endtask

    task compare_result(logic [31:0] off, logic [2:0] sts);
      xlat_result_t want;
      if (!$isunknown(sts)) status_seen[sts]++;
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result offset=%h status=%0d", off, sts));
        return;
      end
      want = awaited_results.pop_front();
      if (off !== want.offset)
        flag_mismatch($sformatf("file_offset %h, expected %h", off, want.offset));
      if (sts !== want.status)
        flag_mismatch($sformatf("status %0d, expected %0d (%s)", sts, want.status,
                                want.status.name()));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_cmd;
  logic [31:0] in_address;
  logic [31:0] in_entry_file_offset;
  logic [31:0] in_entry_ram_base;
  logic [31:0] in_entry_length;
  logic        out_valid;
  logic [31:0] out_file_offset;
  logic [2:0]  out_status;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  section_map_scoreboard book;
  int unsigned cycles = 0;
  int unsigned items_sent;
  int unsigned cmd_count [4];
  bit          no_idle;
  logic [31:0] recent_base[$];
  logic [31:0] recent_size[$];

  section_table_address_translation u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_cmd               (in_cmd),
    .in_address           (in_address),
    .in_entry_file_offset (in_entry_file_offset),
    .in_entry_ram_base    (in_entry_ram_base),
    .in_entry_length      (in_entry_length),
    .out_valid            (out_valid),
    .out_file_offset      (out_file_offset),
    .out_status           (out_status),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, book.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) book.compare_result(out_file_offset, out_status);
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(stat_pkg::cmd_t c, logic [31:0] a, logic [31:0] off,
                           logic [31:0] base, logic [31:0] size);
    int unsigned gap;
    bit          hold;
    gap = pick_gap();
    hold = ($urandom_range(0, 59) == 0);
    if (hold && gap == 0) gap = 1;
    if (gap != 0) start <= 1'b0;
    if (hold) while (book.pending() != 0) @(posedge clk);
    repeat (gap) @(posedge clk);
    start                <= 1'b1;
    in_cmd               <= c;
    in_address           <= a;
    in_entry_file_offset <= off;
    in_entry_ram_base    <= base;
    in_entry_length      <= size;
    do @(posedge clk); while (busy);
    book.apply_command(c, a, off, base, size);
    cmd_count[c]++;
    if (c != stat_pkg::CMD_NONE) items_sent++;
  endtask

  task automatic settle();
    start <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start(logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.prog_start = v;
  endtask

  function automatic logic [31:0] pick_base();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom;
    if (r == 1 && recent_base.size() != 0)
      return recent_base[$urandom_range(0, recent_base.size() - 1)];
    return stat_pkg::RAM_FLOOR + ($urandom_range(0, 32'hFFFF) << 4);
  endfunction

  function automatic logic [31:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return $urandom;
    return $urandom_range(1, 32'h2000);
  endfunction

  function automatic logic [31:0] pick_addr();
    int unsigned r;
    int unsigned i;
    logic [31:0] b;
    logic [31:0] s;
    r = $urandom_range(0, 9);
    if (r == 0 || recent_base.size() == 0) return $urandom;
    if (r == 1) return $urandom_range(0, 32'h7FFF_FFFF);
    i = $urandom_range(0, recent_base.size() - 1);
    b = recent_base[i];
    s = recent_size[i];
    case ($urandom_range(0, 4))
      0: return b - 1;
      1: return b;
      2: return b + s;
      3: return b + s + 1;
      default: return b + $urandom_range(0, s);
    endcase
  endfunction

  task automatic maybe_noise();
    if ($urandom_range(0, 11) == 0)
      send_item(stat_pkg::cmd_t'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                $urandom);
  endtask

  // one program image: optional clear, a batch of sections, then lookups
  task automatic run_program();
    int unsigned n_load;
    int unsigned n_xlate;
    logic [31:0] b;
    logic [31:0] l;
    no_idle = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 3) != 0) begin
      send_item(stat_pkg::CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      recent_base.delete();
      recent_size.delete();
    end
    n_load = ($urandom_range(0, 5) == 0) ? $urandom_range(16, 22) : $urandom_range(0, 6);
    repeat (n_load) begin
      maybe_noise();
      b = pick_base();
      l = pick_len();
      send_item(stat_pkg::CMD_LOAD, $urandom, $urandom, b, l);
      if (l != 0) begin
        recent_base.insert(recent_base.size(), b);
        recent_size.insert(recent_size.size(), l);
      end
    end
    n_xlate = $urandom_range(2, 12);
    repeat (n_xlate) begin
      maybe_noise();
      send_item(stat_pkg::CMD_TRANSLATE, pick_addr(), $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] start_vals [4];
    rst_n                = 1'b0;
    start                = 1'b0;
    in_cmd               = stat_pkg::CMD_CLEAR;
    in_address           = '0;
    in_entry_file_offset = '0;
    in_entry_ram_base    = '0;
    in_entry_length      = '0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    items_sent           = 0;
    no_idle              = 1'b0;
    foreach (cmd_count[i]) cmd_count[i] = 0;
    book = new();
    start_vals[0] = 32'hFFFF_FFFF;
    start_vals[1] = 32'h0000_0000;
    start_vals[2] = $urandom;
    start_vals[3] = 32'h8000_0000;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    write_start(32'h0000_0100);

    // empty table, then sorted inserts, equal bases and a wrapping section
    send_item(stat_pkg::CMD_TRANSLATE, 32'h0000_0000, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h7FFF_FFFF, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_0000, '0, '0, '0);
    send_item(stat_pkg::CMD_LOAD, '0, 32'h0000_0040, 32'h8000_2000, 32'h0);
    send_item(stat_pkg::CMD_LOAD, '0, 32'h0000_0000, 32'h8000_3000, 32'h100);
    send_item(stat_pkg::CMD_LOAD, '0, 32'h0000_0200, 32'h8000_1000, 32'h80);
    send_item(stat_pkg::CMD_LOAD, '0, 32'hFFFF_FFFF, 32'h8000_1000, 32'h10);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_1000, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_1080, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_0FFF, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_2000, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_3101, '0, '0, '0);
    send_item(stat_pkg::CMD_LOAD, '0, 32'h0000_0400, 32'hFFFF_FF00, 32'hFFFF_FFFF);
    send_item(stat_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h1234_5678, '0, '0, '0);
    send_item(stat_pkg::CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF_FFFF);
    send_item(stat_pkg::CMD_CLEAR, '0, '0, '0, '0);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_1000, '0, '0, '0);
    send_item(stat_pkg::CMD_LOAD, '0, 32'h0000_0010, 32'h0000_0000, 32'h1);
    send_item(stat_pkg::CMD_TRANSLATE, 32'h8000_0000, '0, '0, '0);
    send_item(stat_pkg::CMD_LOAD, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(stat_pkg::CMD_TRANSLATE, 32'hFFFF_FFFF, '0, '0, '0);

    for (int p = 0; p < 4; p++) begin
      settle();
      write_start(start_vals[p]);
      while (items_sent < 25 + (p + 1) * (TARGET_ITEMS - 25) / 4) run_program();
    end
    settle();

    $display("%0d transactions (%0d clear, %0d load, %0d translate, %0d unused), 5 offsets",
             items_sent + cmd_count[stat_pkg::CMD_NONE], cmd_count[stat_pkg::CMD_CLEAR],
             cmd_count[stat_pkg::CMD_LOAD], cmd_count[stat_pkg::CMD_TRANSLATE],
             cmd_count[stat_pkg::CMD_NONE]);
    $display("Statuses xlat/pure/before/past/loaded/skipped/full/cleared: %0d/%0d/%0d/%0d/%0d/%0d/%0d/%0d",
             book.status_seen[0], book.status_seen[1], book.status_seen[2], book.status_seen[3],
             book.status_seen[4], book.status_seen[5], book.status_seen[6], book.status_seen[7]);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
